// File: rtl/raster_shape_fill_engine_defines.svh
// assertion macros used by the shape fill engine sequencer
`ifndef RASTER_SHAPE_FILL_ENGINE_DEFINES_SVH
`define RASTER_SHAPE_FILL_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSFE_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rsfe assertion failed");
`define RSFE_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rsfe assertion failed");
`else
`define RSFE_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RSFE_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/rsfe_pkg.sv
// shared types, constants and helper functions of the shape fill engine
package rsfe_pkg;

	localparam int COLS    = 128;
	localparam int ROWS    = 64;
	localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DEPTH   = COLS * ROWS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIX_W   = 8;
	localparam int GLYPH_W = 7;
	localparam int COORD_W = 18;
	localparam int SQ_W    = 32;
	localparam int RAD_W   = 12;
	localparam int LIM_W   = 2 * RAD_W - 8;

	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
	localparam logic [GLYPH_W-1:0] GLYPH_DOT   = 7'd46;
	localparam logic [GLYPH_W-1:0] GLYPH_COLON = 7'd58;
	localparam logic [GLYPH_W-1:0] GLYPH_EQ    = 7'd61;
	localparam logic [GLYPH_W-1:0] GLYPH_QUEST = 7'd63;
	localparam logic [GLYPH_W-1:0] GLYPH_PCT   = 7'd37;
	localparam logic [GLYPH_W-1:0] GLYPH_H     = 7'd72;
	localparam logic [GLYPH_W-1:0] GLYPH_AT    = 7'd64;

	typedef enum logic [2:0] {
		CMD_FILL  = 3'd0,
		CMD_POINT = 3'd1,
		CMD_HLINE = 3'd2,
		CMD_VLINE = 3'd3,
		CMD_RECT  = 3'd4,
		CMD_DISC  = 3'd5,
		CMD_READ  = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SETUP,
		ST_LIM,
		ST_LIM_LD,
		ST_ROW_DY,
		ST_ROW_DX,
		ST_ROW_LD,
		ST_SCAN,
		ST_READ,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} fb_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} fb_rd_t;

	typedef struct packed {
		logic load;
		logic off;
	} res_req_t;

	function automatic logic [COL_W-1:0] clamp_col(input logic signed [COORD_W-1:0] v);
		if (v < 0)
			return '0;
		else if (v > COORD_W'(COLS - 1))
			return COL_W'(COLS - 1);
		else
			return v[COL_W-1:0];
	endfunction

	function automatic logic [ROW_W-1:0] clamp_row(input logic signed [COORD_W-1:0] v);
		if (v < 0)
			return '0;
		else if (v > COORD_W'(ROWS - 1))
			return ROW_W'(ROWS - 1);
		else
			return v[ROW_W-1:0];
	endfunction

	function automatic logic on_canvas(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y);
		return (x >= 0) && (x < COORD_W'(COLS)) && (y >= 0) && (y < COORD_W'(ROWS));
	endfunction

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] y,
		input logic [COL_W-1:0] x);
		return ADDR_W'(ADDR_W'(y) * ADDR_W'(COLS) + ADDR_W'(x));
	endfunction

	function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [PIX_W-1:0] v);
		logic [GLYPH_W-1:0] g;
		case (v[7:5])
			3'd0:    g = GLYPH_SPACE;
			3'd1:    g = GLYPH_DOT;
			3'd2:    g = GLYPH_COLON;
			3'd3:    g = GLYPH_EQ;
			3'd4:    g = GLYPH_QUEST;
			3'd5:    g = GLYPH_PCT;
			3'd6:    g = GLYPH_H;
			default: g = GLYPH_AT;
		endcase
		return g;
	endfunction

endpackage

// File: rtl/rsfe_if.sv
// request and result channel interfaces of the shape fill engine
interface rsfe_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [15:0] x_first;
	logic signed [15:0] x_second;
	logic signed [15:0] y_first;
	logic signed [15:0] y_second;
	logic [11:0]        radius_q4;
	logic [7:0]         shade;

	modport source (output valid, cmd, x_first, x_second, y_first, y_second, radius_q4, shade,
		input ready);
	modport sink (input valid, cmd, x_first, x_second, y_first, y_second, radius_q4, shade,
		output ready);
endinterface

interface rsfe_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic [6:0] glyph;
	logic       off_canvas;

	modport source (output valid, pixel_value, glyph, off_canvas, input ready);
	modport sink (input valid, pixel_value, glyph, off_canvas, output ready);
endinterface

// File: rtl/rsfe_frame_ram.sv
// frame store: one write port, one read port with registered read data
module rsfe_frame_ram (
	input  logic                           clk,
	input  rsfe_pkg::fb_wr_t               wr,
	input  rsfe_pkg::fb_rd_t               rd,
	output logic [rsfe_pkg::PIX_W-1:0]     rd_data
);

	logic [rsfe_pkg::PIX_W-1:0] mem [rsfe_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// File: rtl/rsfe_sq_unit.sv
// shared squaring unit with registered product
module rsfe_sq_unit (
	input  logic                                clk,
	input  logic signed [rsfe_pkg::COORD_W-1:0] op,
	output logic [rsfe_pkg::SQ_W-1:0]           sq_q
);

	logic signed [2*rsfe_pkg::COORD_W-1:0] prod;

	assign prod = op * op;

	always_ff @(posedge clk) begin
		sq_q <= prod[rsfe_pkg::SQ_W-1:0];
	end

endmodule

// File: rtl/rsfe_scan_seq.sv
// command sequencer: store sweep, box scan with disc test, pixel read
`include "raster_shape_fill_engine_defines.svh"

module rsfe_scan_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	rsfe_cmd_if.sink                            req,
	output rsfe_pkg::fb_wr_t                    wr,
	output rsfe_pkg::fb_rd_t                    rd,
	output rsfe_pkg::res_req_t                  res_req,
	input  logic                                res_free,
	output logic signed [rsfe_pkg::COORD_W-1:0] sq_op,
	input  logic [rsfe_pkg::SQ_W-1:0]           sq_res
);

	rsfe_pkg::state_t state_q, state_d;
	rsfe_pkg::cmd_t   cmd_q;

	logic [rsfe_pkg::ADDR_W-1:0] addr_q;
	logic [rsfe_pkg::PIX_W-1:0]  shade_q;
	logic signed [15:0]          xa_q, xb_q, ya_q, yb_q;
	logic [rsfe_pkg::RAD_W-1:0]  r_q;
	logic [rsfe_pkg::COL_W-1:0]  x_q, x0_q, x1_q;
	logic [rsfe_pkg::ROW_W-1:0]  y_q, y1_q;
	logic                        off_q;
	logic [rsfe_pkg::LIM_W-1:0]  lim_q;
	logic [rsfe_pkg::SQ_W-1:0]   dx2_q, dy2_q;

	logic signed [rsfe_pkg::COORD_W-1:0] xa_s, xb_s, ya_s, yb_s, ext_s;
	logic signed [rsfe_pkg::COORD_W-1:0] bx0, bx1, by0, by1;
	logic signed [rsfe_pkg::COORD_W-1:0] dx, dy;
	logic [rsfe_pkg::RAD_W:0]            rsum;
	logic [rsfe_pkg::COL_W-1:0]          cx0, cx1;
	logic [rsfe_pkg::ROW_W-1:0]          cy0, cy1;
	logic                                empty, on_cv, is_disc, covered, row_end, box_end;
	logic signed [rsfe_pkg::SQ_W+1:0]    dx2_nx;
	logic [rsfe_pkg::SQ_W:0]             dsum;
	logic                                fill_acc, fill_begun, in_box;

	assign xa_s    = rsfe_pkg::COORD_W'(xa_q);
	assign xb_s    = rsfe_pkg::COORD_W'(xb_q);
	assign ya_s    = rsfe_pkg::COORD_W'(ya_q);
	assign yb_s    = rsfe_pkg::COORD_W'(yb_q);
	assign rsum    = (rsfe_pkg::RAD_W+1)'(r_q) + (rsfe_pkg::RAD_W+1)'(15);
	assign ext_s   = rsfe_pkg::COORD_W'($signed({1'b0, rsum[rsfe_pkg::RAD_W:4]}));
	assign is_disc = (cmd_q == rsfe_pkg::CMD_DISC);

	always_comb begin
		bx0 = xa_s;
		bx1 = xa_s;
		by0 = ya_s;
		by1 = ya_s;
		case (cmd_q)
			rsfe_pkg::CMD_HLINE: begin
				bx1 = xb_s;
			end
			rsfe_pkg::CMD_VLINE: begin
				by1 = yb_s;
			end
			rsfe_pkg::CMD_RECT: begin
				bx1 = xb_s;
				by1 = yb_s;
			end
			rsfe_pkg::CMD_DISC: begin
				bx0 = xa_s - ext_s;
				bx1 = xa_s + ext_s;
				by0 = ya_s - ext_s;
				by1 = ya_s + ext_s;
			end
			default: begin
			end
		endcase
	end

	assign cx0   = rsfe_pkg::clamp_col(bx0);
	assign cx1   = rsfe_pkg::clamp_col(bx1);
	assign cy0   = rsfe_pkg::clamp_row(by0);
	assign cy1   = rsfe_pkg::clamp_row(by1);
	assign empty = (cx0 > cx1) || (cy0 > cy1);
	assign on_cv = rsfe_pkg::on_canvas(xa_s, ya_s);

	assign dx      = rsfe_pkg::COORD_W'($signed({1'b0, x_q})) - xa_s;
	assign dy      = rsfe_pkg::COORD_W'($signed({1'b0, y_q})) - ya_s;
	assign dsum    = (rsfe_pkg::SQ_W+1)'(dx2_q) + (rsfe_pkg::SQ_W+1)'(dy2_q);
	assign covered = !is_disc || (dsum <= (rsfe_pkg::SQ_W+1)'(lim_q));
	assign dx2_nx  = $signed({2'b00, dx2_q}) + ((rsfe_pkg::SQ_W+2)'(dx) <<< 1)
		+ (rsfe_pkg::SQ_W+2)'(1);
	assign row_end = (x_q == x1_q);
	assign box_end = row_end && (y_q == y1_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsfe_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (rsfe_pkg::cmd_t'(req.cmd) == rsfe_pkg::CMD_FILL)
						state_d = rsfe_pkg::ST_FILL;
					else if (req.cmd inside {rsfe_pkg::CMD_POINT, rsfe_pkg::CMD_HLINE,
						rsfe_pkg::CMD_VLINE, rsfe_pkg::CMD_RECT, rsfe_pkg::CMD_DISC,
						rsfe_pkg::CMD_READ})
						state_d = rsfe_pkg::ST_SETUP;
				end
			end
			rsfe_pkg::ST_FILL: begin
				if (addr_q == rsfe_pkg::ADDR_W'(rsfe_pkg::DEPTH - 1))
					state_d = rsfe_pkg::ST_IDLE;
			end
			rsfe_pkg::ST_SETUP: begin
				case (cmd_q)
					rsfe_pkg::CMD_POINT: state_d = on_cv ? rsfe_pkg::ST_SCAN : rsfe_pkg::ST_IDLE;
					rsfe_pkg::CMD_READ:  state_d = on_cv ? rsfe_pkg::ST_READ : rsfe_pkg::ST_RESULT;
					rsfe_pkg::CMD_DISC:  state_d = rsfe_pkg::ST_LIM;
					rsfe_pkg::CMD_HLINE, rsfe_pkg::CMD_VLINE, rsfe_pkg::CMD_RECT:
						state_d = empty ? rsfe_pkg::ST_IDLE : rsfe_pkg::ST_SCAN;
					default: state_d = rsfe_pkg::ST_IDLE;
				endcase
			end
			rsfe_pkg::ST_LIM:    state_d = rsfe_pkg::ST_LIM_LD;
			rsfe_pkg::ST_LIM_LD: state_d = rsfe_pkg::ST_ROW_DY;
			rsfe_pkg::ST_ROW_DY: state_d = rsfe_pkg::ST_ROW_DX;
			rsfe_pkg::ST_ROW_DX: state_d = rsfe_pkg::ST_ROW_LD;
			rsfe_pkg::ST_ROW_LD: state_d = rsfe_pkg::ST_SCAN;
			rsfe_pkg::ST_SCAN: begin
				if (box_end)
					state_d = rsfe_pkg::ST_IDLE;
				else if (row_end && is_disc)
					state_d = rsfe_pkg::ST_ROW_DY;
			end
			rsfe_pkg::ST_READ: state_d = rsfe_pkg::ST_RESULT;
			rsfe_pkg::ST_RESULT: begin
				if (res_free)
					state_d = rsfe_pkg::ST_IDLE;
			end
			default: state_d = rsfe_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready    = (state_q == rsfe_pkg::ST_IDLE);
		wr.en        = 1'b0;
		wr.addr      = rsfe_pkg::pix_addr(y_q, x_q);
		wr.data      = shade_q;
		rd.en        = (state_q == rsfe_pkg::ST_READ);
		rd.addr      = rsfe_pkg::pix_addr(y_q, x_q);
		res_req.load = (state_q == rsfe_pkg::ST_RESULT);
		res_req.off  = off_q;
		sq_op        = '0;
		case (state_q)
			rsfe_pkg::ST_FILL: begin
				wr.en   = 1'b1;
				wr.addr = addr_q;
			end
			rsfe_pkg::ST_SCAN:   wr.en = covered;
			rsfe_pkg::ST_LIM:    sq_op = rsfe_pkg::COORD_W'($signed({1'b0, r_q}));
			rsfe_pkg::ST_ROW_DY: sq_op = dy;
			rsfe_pkg::ST_ROW_DX: sq_op = dx;
			default: begin
			end
		endcase
	end

	// reset clears the store through the fill sweep with shade zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsfe_pkg::ST_FILL;
			addr_q  <= '0;
			shade_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rsfe_pkg::ST_IDLE && req.valid) begin
				addr_q  <= '0;
				shade_q <= req.shade;
			end else if (state_q == rsfe_pkg::ST_FILL) begin
				addr_q <= addr_q + rsfe_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rsfe_pkg::ST_IDLE: begin
				if (req.valid) begin
					cmd_q <= rsfe_pkg::cmd_t'(req.cmd);
					xa_q  <= req.x_first;
					xb_q  <= req.x_second;
					ya_q  <= req.y_first;
					yb_q  <= req.y_second;
					r_q   <= req.radius_q4;
				end
			end
			rsfe_pkg::ST_SETUP: begin
				x_q   <= cx0;
				x0_q  <= cx0;
				x1_q  <= cx1;
				y_q   <= cy0;
				y1_q  <= cy1;
				off_q <= !on_cv;
			end
			rsfe_pkg::ST_LIM_LD: lim_q <= sq_res[2*rsfe_pkg::RAD_W-1:8];
			rsfe_pkg::ST_ROW_DX: dy2_q <= sq_res;
			rsfe_pkg::ST_ROW_LD: dx2_q <= sq_res;
			rsfe_pkg::ST_SCAN: begin
				dx2_q <= dx2_nx[rsfe_pkg::SQ_W-1:0];
				if (row_end) begin
					x_q <= x0_q;
					y_q <= y_q + rsfe_pkg::ROW_W'(1);
				end else begin
					x_q <= x_q + rsfe_pkg::COL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign fill_acc   = req.valid && req.ready && (req.cmd == rsfe_pkg::CMD_FILL);
	assign fill_begun = (state_q == rsfe_pkg::ST_FILL) && (addr_q == '0);
	assign in_box     = (x_q >= x0_q) && (x_q <= x1_q) && (y_q <= y1_q);

	`RSFE_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == rsfe_pkg::ST_IDLE, !wr.en)
	`RSFE_ASSERT_NXT(a_fill_starts, clk, arst_n, fill_acc, fill_begun)
	`RSFE_ASSERT_IMP(a_scan_in_box, clk, arst_n, state_q == rsfe_pkg::ST_SCAN, in_box)
	`RSFE_ASSERT_NXT(a_read_then_result, clk, arst_n, rd.en, state_q == rsfe_pkg::ST_RESULT)

endmodule

// File: rtl/raster_shape_fill_engine.sv
// Greyscale frame store of 128 x 64 pixels with a drawing command port and a pixel read result
// port. After reset the store is cleared by a sweep of all 8192 pixels, one pixel a cycle,
// during which no request is taken; a fill command takes the same sweep after it is accepted.
// Lines, rectangles and points pass through a setup state, then write one pixel a cycle of the
// clamped box, set by the single write port of the frame store. A circle passes through the
// setup and radius limit states, then the row states at the start of each row of its box
// (the shared squaring unit forms the squares of the row and first column distances) and scans
// one pixel a cycle. A read passes through setup and, on the canvas, the read state before its
// result is held in the output register; shape commands go on while it waits to be taken.
module raster_shape_fill_engine (
	input  logic      clk,
	input  logic      arst_n,
	rsfe_cmd_if.sink  req,
	rsfe_res_if.source res
);

	rsfe_pkg::fb_wr_t   wr;
	rsfe_pkg::fb_rd_t   rd;
	rsfe_pkg::res_req_t res_req;

	logic [rsfe_pkg::PIX_W-1:0]          rd_data;
	logic signed [rsfe_pkg::COORD_W-1:0] sq_op;
	logic [rsfe_pkg::SQ_W-1:0]           sq_res;
	logic                                res_free;
	logic                                out_valid_q;
	logic [rsfe_pkg::PIX_W-1:0]          pixel_q;
	logic [rsfe_pkg::GLYPH_W-1:0]        glyph_q;
	logic                                off_q;
	logic [rsfe_pkg::PIX_W-1:0]          pixel_d;

	rsfe_scan_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.wr       (wr),
		.rd       (rd),
		.res_req  (res_req),
		.res_free (res_free),
		.sq_op    (sq_op),
		.sq_res   (sq_res)
	);

	rsfe_sq_unit u_sq (
		.clk  (clk),
		.op   (sq_op),
		.sq_q (sq_res)
	);

	rsfe_frame_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign res_free = !out_valid_q || res.ready;
	assign pixel_d  = res_req.off ? '0 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_req.load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_req.load) begin
			pixel_q <= pixel_d;
			glyph_q <= rsfe_pkg::ramp_glyph(pixel_d);
			off_q   <= res_req.off;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.pixel_value = pixel_q;
	assign res.glyph       = glyph_q;
	assign res.off_canvas  = off_q;

endmodule
